FILE: sv/boot_sector_classifier_core_defines.svh
// assertion macros for the boot sector classifier checker
// no dependencies; included by the checker file
`ifndef BOOT_SECTOR_CLASSIFIER_CORE_DEFINES_SVH
`define BOOT_SECTOR_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define BSC_CHECK_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define BSC_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/bsc_pkg.sv
// shared types, constants and the loader string table for the boot sector classifier
// no dependencies
`default_nettype none

package bsc_pkg;

   localparam int unsigned MAX_SECTOR_BYTES = 4096;
   localparam int unsigned COUNT_W = $clog2(MAX_SECTOR_BYTES + 1);

   localparam int unsigned PAT_COUNT = 8;
   localparam int unsigned PAT_MAX = 11;
   localparam int unsigned WIN_DEPTH = PAT_MAX - 1;
   localparam int unsigned FLAG_COUNT = 4;

   localparam logic [7:0] SIG_LOW = 8'h55;
   localparam logic [7:0] SIG_HIGH = 8'hAA;
   localparam logic [7:0] JMP_SHORT = 8'hEB;
   localparam logic [7:0] JMP_NEAR = 8'hE9;

   localparam int unsigned FLAG_IO = 0;
   localparam int unsigned FLAG_MSDOS = 1;
   localparam int unsigned FLAG_IBM = 2;
   localparam int unsigned FLAG_NONSYS = 3;

   // upper-case text, last character in the low byte
   localparam logic [8*PAT_MAX-1:0] PAT_TEXT [PAT_COUNT] = '{
      "IO      SYS", "IO.SYS", "MSDOS   SYS", "MSDOS.SYS",
      "IBMBIO", "IBMDOS", "NON-SYSTEM", "NON SYSTEM"
   };
   localparam int unsigned PAT_LEN [PAT_COUNT] = '{11, 6, 11, 9, 6, 6, 10, 10};
   localparam int unsigned PAT_FLAG [PAT_COUNT] = '{
      FLAG_IO, FLAG_IO, FLAG_MSDOS, FLAG_MSDOS, FLAG_IBM, FLAG_IBM, FLAG_NONSYS, FLAG_NONSYS
   };

   typedef enum logic [2:0] {
      KIND_NONE       = 3'd0,
      KIND_SIG_ONLY   = 3'd1,
      KIND_CUSTOM     = 3'd2,
      KIND_DOS_NONSYS = 3'd3,
      KIND_CUSTOM_SIG = 3'd4
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } cell_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'h20;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: sv/bsc_cell.sv
// one window cell: holds a sector byte and its in-sector mark, passes both on
// depends on bsc_pkg
`default_nettype none

module bsc_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    shift_en,
   input  wire                    flush,
   input  wire bsc_pkg::cell_type prev,
   output bsc_pkg::cell_type      cur,
   output logic [7:0]             folded
);
   import bsc_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      if (flush) begin
         valid_in = 1'b0;
      end else if (shift_en) begin
         valid_in = prev.valid;
         data_in = prev.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign cur.valid = valid_ff;
   assign cur.data = data_ff;
   assign folded = fold(data_ff);

endmodule

`default_nettype wire

FILE: sv/bsc_match.sv
// parallel compare of the byte window against the loader string table
// depends on bsc_pkg
`default_nettype none

module bsc_match (
   input  wire [7:0]                  win_bytes [bsc_pkg::PAT_MAX],
   input  wire [bsc_pkg::WIN_DEPTH-1:0] win_valid,
   output logic [bsc_pkg::FLAG_COUNT-1:0] hits
);
   import bsc_pkg::*;

   logic ok;

   always_comb begin
      ok = 1'b0;
      hits = '0;
      for (int i = 0; i < PAT_COUNT; i++) begin
         // deepest cell used must still belong to this sector
         ok = win_valid[PAT_LEN[i] - 2];
         for (int k = 0; k < PAT_MAX; k++) begin
            if (k < PAT_LEN[i] && win_bytes[k] != PAT_TEXT[i][8*k +: 8]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            hits[PAT_FLAG[i]] = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/boot_sector_classifier_core.sv
// boot sector classifier top: window cell chain, string matcher, sector tracking, result register
// depends on bsc_pkg, bsc_cell, bsc_match
//
//   channel   ports   direction   content
//   request   req_    in          data_byte, last_byte, bpb_valid
//   response  rsp_    out         boot_kind, custom_boot and six detection flags
//
// one byte per cycle while req_stall is low; every byte is compared in the cycle it
// arrives, against the ten-cell window and the current byte
// the response word is registered and appears in the cycle after the last byte is taken
// req_stall is high only while a response word waits under rsp_stall
// reset clears the window marks, byte count, loader flags and response valid
`default_nettype none

module boot_sector_classifier_core (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [7:0]  req_data_byte,
   input  wire        req_last_byte,
   input  wire        req_bpb_valid,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [2:0] rsp_boot_kind,
   output logic       rsp_custom_boot,
   output logic       rsp_jump_seen,
   output logic       rsp_signature_seen,
   output logic       rsp_io_sys_seen,
   output logic       rsp_msdos_sys_seen,
   output logic       rsp_ibm_name_seen,
   output logic       rsp_non_system_seen
);
   import bsc_pkg::*;

   cell_type                chain [WIN_DEPTH+1];
   logic [7:0]              win_bytes [PAT_MAX];
   logic [WIN_DEPTH-1:0]    win_valid;
   logic [FLAG_COUNT-1:0]   hits;
   logic                    accept, shift_en, flush;

   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [7:0]              first_ff, first_in;
   logic [7:0]              b510_ff, b510_in;
   logic [7:0]              b511_ff, b511_in;
   logic [FLAG_COUNT-1:0]   flags_ff, flags_in;
   logic [FLAG_COUNT-1:0]   seen;
   logic [7:0]              last_pair_high;
   logic                    jmp, sig, loader;

   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                kind_ff, kind_in;
   logic                    booter_ff, booter_in;
   logic                    jump_ff, sig_ff;
   logic [FLAG_COUNT-1:0]   out_flags_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;
   assign shift_en = accept & ~req_last_byte;
   assign flush = accept & req_last_byte;

   // window chain
   assign chain[0].valid = 1'b1;
   assign chain[0].data = req_data_byte;
   assign win_bytes[0] = fold(req_data_byte);

   for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
      bsc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .flush    (flush),
         .prev     (chain[g]),
         .cur      (chain[g+1]),
         .folded   (win_bytes[g+1])
      );
      assign win_valid[g] = chain[g+1].valid;
   end

   bsc_match u_match (
      .win_bytes (win_bytes),
      .win_valid (win_valid),
      .hits      (hits)
   );

   // sector tracking
   always_comb begin
      seen = flags_ff | hits;
      last_pair_high = (count_ff == COUNT_W'(511)) ? req_data_byte : b511_ff;
      if (count_ff >= COUNT_W'(511)) begin
         sig = (b510_ff == SIG_LOW) && (last_pair_high == SIG_HIGH);
      end else if (count_ff >= COUNT_W'(1)) begin
         sig = (chain[1].data == SIG_LOW) && (req_data_byte == SIG_HIGH);
      end else begin
         sig = 1'b0;
      end
      jmp = (count_ff >= COUNT_W'(2)) && (first_ff == JMP_SHORT || first_ff == JMP_NEAR);
      loader = |seen;

      if (!jmp && !sig) begin
         kind_in = KIND_NONE;
      end else if (!jmp) begin
         kind_in = KIND_SIG_ONLY;
      end else if (!sig) begin
         kind_in = KIND_CUSTOM;
      end else if (loader && req_bpb_valid) begin
         kind_in = KIND_DOS_NONSYS;
      end else begin
         kind_in = KIND_CUSTOM_SIG;
      end
      booter_in = (kind_in == KIND_CUSTOM) || (kind_in == KIND_CUSTOM_SIG);

      count_in = count_ff;
      first_in = first_ff;
      b510_in = b510_ff;
      b511_in = b511_ff;
      flags_in = flags_ff;
      if (flush) begin
         count_in = '0;
         first_in = '0;
         b510_in = '0;
         b511_in = '0;
         flags_in = '0;
      end else if (shift_en) begin
         if (count_ff < COUNT_W'(MAX_SECTOR_BYTES)) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if (count_ff == '0) begin
            first_in = req_data_byte;
         end
         if (count_ff == COUNT_W'(510)) begin
            b510_in = req_data_byte;
         end
         if (count_ff == COUNT_W'(511)) begin
            b511_in = req_data_byte;
         end
         flags_in = seen;
      end

      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (flush) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
         b510_ff <= '0;
         b511_ff <= '0;
         flags_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         first_ff <= first_in;
         b510_ff <= b510_in;
         b511_ff <= b511_in;
         flags_ff <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (flush) begin
         kind_ff <= kind_in;
         booter_ff <= booter_in;
         jump_ff <= jmp;
         sig_ff <= sig;
         out_flags_ff <= seen;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_boot_kind = kind_ff;
   assign rsp_custom_boot = booter_ff;
   assign rsp_jump_seen = jump_ff;
   assign rsp_signature_seen = sig_ff;
   assign rsp_io_sys_seen = out_flags_ff[FLAG_IO];
   assign rsp_msdos_sys_seen = out_flags_ff[FLAG_MSDOS];
   assign rsp_ibm_name_seen = out_flags_ff[FLAG_IBM];
   assign rsp_non_system_seen = out_flags_ff[FLAG_NONSYS];

endmodule

`default_nettype wire

FILE: sv/bsc_checker.sv
// port-level checks for the boot sector classifier, bound to the top level
// depends on bsc_pkg and boot_sector_classifier_core_defines.svh
`default_nettype none
`include "boot_sector_classifier_core_defines.svh"

module bsc_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_stall,
   input wire       req_last_byte,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [2:0] rsp_boot_kind,
   input wire       rsp_custom_boot,
   input wire       rsp_jump_seen,
   input wire       rsp_signature_seen,
   input wire       rsp_io_sys_seen,
   input wire       rsp_msdos_sys_seen,
   input wire       rsp_ibm_name_seen,
   input wire       rsp_non_system_seen
);
   import bsc_pkg::*;

   logic any_loader, kind_custom, kind_none_ok, rsp_take, req_take;

   assign any_loader = rsp_io_sys_seen | rsp_msdos_sys_seen | rsp_ibm_name_seen
                       | rsp_non_system_seen;
   assign kind_custom = (rsp_boot_kind == KIND_CUSTOM) || (rsp_boot_kind == KIND_CUSTOM_SIG);
   assign kind_none_ok = (rsp_boot_kind == KIND_NONE)
                         == (!rsp_jump_seen && !rsp_signature_seen);
   assign rsp_take = rsp_valid & ~rsp_stall;
   assign req_take = req_valid & ~req_stall;

   // a stalled word holds
   `BSC_CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_boot_kind) && $stable(rsp_signature_seen), "response word changed under stall")

   `BSC_CHECK_NOW(a_booter_kind, clock, reset, rsp_valid, rsp_custom_boot == kind_custom, "booter flag disagrees with kind")

   `BSC_CHECK_NOW(a_kind_none, clock, reset, rsp_valid, kind_none_ok, "kind zero disagrees with jump and signature")

   `BSC_CHECK_NOW(a_dos_loader, clock, reset, rsp_valid && rsp_boot_kind == KIND_DOS_NONSYS, any_loader && rsp_jump_seen && rsp_signature_seen, "dos kind without loader evidence")

   // a taken word with no new last byte leaves the output empty
   `BSC_CHECK_NEXT(a_no_extra, clock, reset, rsp_take && !(req_take && req_last_byte), !rsp_valid, "response word repeated")

endmodule

bind boot_sector_classifier_core bsc_checker u_bsc_checker (.*);

`default_nettype wire
